/* sv/sscd_pkg.sv */
package sscd_pkg;

   localparam int SIZE_X = 64;
   localparam int SIZE_Y = 64;
   localparam int SIZE_Z = 64;
   localparam int FRAC_BITS = 8;
   localparam int ID_OFFSET = 1000;
   localparam int VOXELS = SIZE_X * SIZE_Y * SIZE_Z;

   localparam int ADDR_W = (VOXELS > 1) ? $clog2(VOXELS) : 1;
   localparam int X_W = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
   localparam int Y_W = (SIZE_Y > 1) ? $clog2(SIZE_Y) : 1;
   localparam int Z_W = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
   localparam int XY_W = (X_W > Y_W) ? X_W : Y_W;
   localparam int IDX_W = (XY_W > Z_W) ? XY_W : Z_W;

   localparam int POS_W = 16;
   localparam int ID_W = 16;
   localparam int RD_W = 6;
   localparam int CNT_W = 16;
   localparam int SPC_W = 16;
   localparam int FILT_W = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = FILT_W;
   localparam int EPOCH_W = 8;
   localparam int Q_DEPTH = 2;
   localparam int QP_W = $clog2(Q_DEPTH);

   // radius scaled to the squared-distance domain
   localparam int BIGR_W = SPC_W + FRAC_BITS;
   localparam int H_W = BIGR_W + 2;
   localparam int DIV_CNT_W = $clog2(BIGR_W);
   localparam int SH_W = (IDX_W + FRAC_BITS > POS_W) ? IDX_W + FRAC_BITS : POS_W;
   localparam int D_W = SH_W + 2;
   localparam int M_W = D_W - 1 + SPC_W;
   localparam int T_W = 2 * M_W;
   localparam int S_W = T_W + 2;

   localparam logic [1:0] OP_SPLAT = 2'd0;
   localparam logic [1:0] OP_EOF = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING_Z = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER = 3'd4;

   typedef struct packed {
      logic [1:0] op;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [ID_W-1:0] marker_id;
      logic [RD_W-1:0] read_x;
      logic [RD_W-1:0] read_y;
      logic [RD_W-1:0] read_z;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] count_value;
      logic [CNT_W-1:0] max_count;
      logic marker_used;
   } rsp_type;

   typedef struct packed {
      logic [SPC_W-1:0] radius_mm;
      logic [SPC_W-1:0] spacing_x;
      logic [SPC_W-1:0] spacing_y;
      logic [SPC_W-1:0] spacing_z;
      logic signed [FILT_W-1:0] structure_filter;
   } cfg_type;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_NEAR,
      CMD_SPHERE,
      CMD_EOF,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [X_W-1:0] vx;
      logic [Y_W-1:0] vy;
      logic [Z_W-1:0] vz;
      logic rd_ok;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_MUL,
      ST_SQ,
      ST_CMP,
      ST_HIT,
      ST_MCLEAR,
      ST_DONE
   } back_state_type;

   function automatic logic [ADDR_W-1:0] vox_addr(input logic [X_W-1:0] x,
                                                  input logic [Y_W-1:0] y,
                                                  input logic [Z_W-1:0] z);
      logic [ADDR_W-1:0] a;
      a = ADDR_W'(ADDR_W'(x) * ADDR_W'(SIZE_Y) + ADDR_W'(y));
      a = ADDR_W'(a * ADDR_W'(SIZE_Z) + ADDR_W'(z));
      return a;
   endfunction

endpackage

/* sv/sphere_splat_density_counter.sv */
// Landmark density map over a 64x64x64 voxel volume. Each word is a marker
// splat, an end-of-file that forgets which voxels this file already hit, a
// count read-back or a no-op; every word returns exactly one response word.
// After reset the block sweeps both voxel memories with req_ready low. A
// sphere marker first finds its bounding box (one serial divider, 24 steps
// per axis) and then visits the box voxel by voxel through the
// squared-distance pipeline: MUL, SQ and CMP for every voxel, and HIT after
// them for a voxel inside the sphere. Every 255th end-of-file rolls over the
// mark epoch and triggers a sweep of the mark memory. A two-word queue behind
// the input lets the next word in while one works.
module sphere_splat_density_counter import sscd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type cfg_ff, cfg_in;
   logic q_full, q_empty, q_push, q_pop, clearing;
   cmd_type q_cmd, q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RADIUS: cfg_in.radius_mm = csr_wr_data[SPC_W-1:0];
            CSR_SPACING_X: cfg_in.spacing_x = csr_wr_data[SPC_W-1:0];
            CSR_SPACING_Y: cfg_in.spacing_y = csr_wr_data[SPC_W-1:0];
            CSR_SPACING_Z: cfg_in.spacing_z = csr_wr_data[SPC_W-1:0];
            CSR_FILTER: cfg_in.structure_filter = csr_wr_data[FILT_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius_mm <= '0;
         cfg_ff.spacing_x <= SPC_W'(1 << FRAC_BITS);
         cfg_ff.spacing_y <= SPC_W'(1 << FRAC_BITS);
         cfg_ff.spacing_z <= SPC_W'(1 << FRAC_BITS);
         cfg_ff.structure_filter <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sscd_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .clearing  (clearing),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   sscd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   sscd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/sscd_ram.sv */
module sscd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/sscd_div.sv */
module sscd_div import sscd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [BIGR_W-1:0] dividend,
   input  logic [SPC_W-1:0]  divisor,
   output logic              done,
   output logic [BIGR_W-1:0] quotient
);

   logic [SPC_W:0] rem_ff, rem_in, rem_sh;
   logic [BIGR_W-1:0] quo_ff, quo_in;
   logic [SPC_W-1:0] dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh = {rem_ff[SPC_W-1:0], quo_ff[BIGR_W-1]};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            quo_in = {quo_ff[BIGR_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[BIGR_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(BIGR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

/* sv/sscd_fifo.sv */
module sscd_fifo import sscd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type mem_ff [Q_DEPTH];
   logic [QP_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QP_W:0] cnt_ff, cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full = (cnt_ff == (QP_W+1)'(Q_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head = mem_ff[rd_ptr_ff];

endmodule

/* sv/sscd_front.sv */
module sscd_front import sscd_pkg::*; (
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  cfg_type cfg,
   input  logic    q_full,
   input  logic    clearing,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic signed [ID_W+1:0] filt_w, id_w, id_off_w;
   logic filt_ok, in_vol;
   int px, py, pz;

   function automatic logic axis_inside(input int p, input int size);
      return (2 * p >= -(1 << FRAC_BITS)) && (2 * p < (2 * size - 1) * (1 << FRAC_BITS));
   endfunction

   function automatic int nearest(input int p);
      return (p + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   always_comb begin
      px = req_data.pos_x;
      py = req_data.pos_y;
      pz = req_data.pos_z;
      filt_w = {cfg.structure_filter[FILT_W-1], cfg.structure_filter};
      id_w = {2'b00, req_data.marker_id};
      id_off_w = id_w + (ID_W+2)'(ID_OFFSET);
      filt_ok = filt_w[ID_W+1] || (filt_w == id_w) || (filt_w == id_off_w);
      in_vol = axis_inside(px, SIZE_X) && axis_inside(py, SIZE_Y) && axis_inside(pz, SIZE_Z);

      q_cmd.pos_x = req_data.pos_x;
      q_cmd.pos_y = req_data.pos_y;
      q_cmd.pos_z = req_data.pos_z;
      q_cmd.rd_ok = (int'(req_data.read_x) < SIZE_X) && (int'(req_data.read_y) < SIZE_Y) &&
                    (int'(req_data.read_z) < SIZE_Z);
      q_cmd.vx = X_W'(nearest(px));
      q_cmd.vy = Y_W'(nearest(py));
      q_cmd.vz = Z_W'(nearest(pz));
      q_cmd.kind = CMD_NOP;
      case (req_data.op)
         OP_SPLAT: begin
            if (filt_ok && in_vol) begin
               q_cmd.kind = (cfg.radius_mm == '0) ? CMD_NEAR : CMD_SPHERE;
            end
         end
         OP_EOF: begin
            q_cmd.kind = CMD_EOF;
         end
         OP_READ: begin
            q_cmd.kind = CMD_READ;
            q_cmd.vx = X_W'(req_data.read_x);
            q_cmd.vy = Y_W'(req_data.read_y);
            q_cmd.vz = Z_W'(req_data.read_z);
         end
         default: begin
            q_cmd.kind = CMD_NOP;
         end
      endcase
   end

   assign req_ready = !q_full && !clearing;
   assign q_push = req_valid && req_ready;

endmodule

/* sv/sscd_back.sv */
module sscd_back import sscd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_empty,
   input  cmd_type q_head,
   output logic    q_pop,
   output logic    clearing,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   back_state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [IDX_W-1:0] cur_ff [3], cur_in [3], nxt [3];
   logic [IDX_W-1:0] lo_ff [3], lo_in [3], hi_ff [3], hi_in [3];
   logic [1:0] axis_ff, axis_in;
   logic empty_ff, empty_in;
   logic [M_W-1:0] m_ff [3], m_in [3];
   logic [T_W-1:0] t_ff [3], t_in [3];
   logic [2*BIGR_W-1:0] r2_ff, r2_in;
   logic [CNT_W-1:0] max_ff, max_in, value_ff, value_in;
   logic used_ff, used_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [SPC_W-1:0] spc [3];
   logic signed [POS_W-1:0] pos [3];
   logic signed [D_W-1:0] d_v [3];
   logic [D_W-2:0] ad_v [3];
   logic [S_W-1:0] dist_sum;
   logic in_sphere, done_box, marked;
   logic [BIGR_W-1:0] big_r;

   logic [SPC_W-1:0] spc_sel;
   logic signed [POS_W-1:0] pos_sel;
   logic signed [H_W-1:0] size_m1, h_s, p_s, lo_raw, hi_raw, lo_cl, hi_cl;
   logic box_empty, div_start, div_done;
   logic [BIGR_W-1:0] div_quo;

   logic [ADDR_W-1:0] cur_addr, head_addr, rd_addr, wr_addr;
   logic cnt_we, mark_we;
   logic [CNT_W-1:0] cnt_rd, cnt_wd, new_cnt;
   logic [EPOCH_W-1:0] mark_rd, mark_wd;

   sscd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (big_r),
      .divisor  (spc_sel),
      .done     (div_done),
      .quotient (div_quo)
   );

   sscd_ram #(.WIDTH(CNT_W), .DEPTH(VOXELS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (wr_addr),
      .wr_data (cnt_wd),
      .rd_addr (rd_addr),
      .rd_data (cnt_rd)
   );

   // mark entry holds the file epoch it was last hit in
   sscd_ram #(.WIDTH(EPOCH_W), .DEPTH(VOXELS)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (wr_addr),
      .wr_data (mark_wd),
      .rd_addr (rd_addr),
      .rd_data (mark_rd)
   );

   assign spc[0] = cfg.spacing_x;
   assign spc[1] = cfg.spacing_y;
   assign spc[2] = cfg.spacing_z;
   assign pos[0] = cmd_ff.pos_x;
   assign pos[1] = cmd_ff.pos_y;
   assign pos[2] = cmd_ff.pos_z;
   assign big_r = {cfg.radius_mm, {FRAC_BITS{1'b0}}};
   assign r2_in = (2*BIGR_W)'(big_r) * (2*BIGR_W)'(big_r);

   assign cur_addr = vox_addr(X_W'(cur_ff[0]), Y_W'(cur_ff[1]), Z_W'(cur_ff[2]));
   assign head_addr = vox_addr(q_head.vx, q_head.vy, q_head.vz);

   assign marked = (mark_rd == epoch_ff);
   assign new_cnt = (&cnt_rd) ? cnt_rd : cnt_rd + 1'b1;

   // per-axis distance terms: |i*2^F - p| * spacing, then squared
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         d_v[a] = $signed(D_W'({cur_ff[a], {FRAC_BITS{1'b0}}})) - D_W'(pos[a]);
         ad_v[a] = (D_W-1)'(d_v[a][D_W-1] ? -d_v[a] : d_v[a]);
         m_in[a] = M_W'(ad_v[a]) * M_W'(spc[a]);
         t_in[a] = T_W'(m_ff[a]) * T_W'(m_ff[a]);
      end
      dist_sum = S_W'(t_ff[0]) + S_W'(t_ff[1]) + S_W'(t_ff[2]);
      in_sphere = (dist_sum <= S_W'(r2_ff));
   end

   // z fastest, then y, then x
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         nxt[a] = cur_ff[a];
      end
      done_box = 1'b0;
      if (cur_ff[2] != hi_ff[2]) begin
         nxt[2] = cur_ff[2] + 1'b1;
      end else begin
         nxt[2] = lo_ff[2];
         if (cur_ff[1] != hi_ff[1]) begin
            nxt[1] = cur_ff[1] + 1'b1;
         end else begin
            nxt[1] = lo_ff[1];
            if (cur_ff[0] != hi_ff[0]) begin
               nxt[0] = cur_ff[0] + 1'b1;
            end else begin
               done_box = 1'b1;
            end
         end
      end
   end

   // bounding box of one axis from h = floor(R / spacing)
   always_comb begin
      case (axis_ff)
         2'd0: begin
            spc_sel = cfg.spacing_x;
            pos_sel = cmd_ff.pos_x;
            size_m1 = H_W'(SIZE_X - 1);
         end
         2'd1: begin
            spc_sel = cfg.spacing_y;
            pos_sel = cmd_ff.pos_y;
            size_m1 = H_W'(SIZE_Y - 1);
         end
         default: begin
            spc_sel = cfg.spacing_z;
            pos_sel = cmd_ff.pos_z;
            size_m1 = H_W'(SIZE_Z - 1);
         end
      endcase
      h_s = $signed({2'b00, div_quo});
      p_s = $signed({{(H_W-POS_W){pos_sel[POS_W-1]}}, pos_sel});
      lo_raw = -((h_s - p_s) >>> FRAC_BITS);
      hi_raw = (p_s + h_s) >>> FRAC_BITS;
      lo_cl = lo_raw[H_W-1] ? '0 : lo_raw;
      hi_cl = (hi_raw > size_m1) ? size_m1 : hi_raw;
      box_empty = (lo_cl > hi_cl);
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      axis_in = axis_ff;
      empty_in = empty_ff;
      max_in = max_ff;
      value_in = value_ff;
      used_in = used_ff;
      epoch_in = epoch_ff;
      clr_in = clr_ff;
      for (int a = 0; a < 3; a++) begin
         cur_in[a] = cur_ff[a];
         lo_in[a] = lo_ff[a];
         hi_in[a] = hi_ff[a];
      end
      q_pop = 1'b0;
      div_start = 1'b0;
      cnt_we = 1'b0;
      mark_we = 1'b0;
      wr_addr = cur_addr;
      rd_addr = cur_addr;
      cnt_wd = new_cnt;
      mark_wd = epoch_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;

      case (state_ff)
         ST_CLEAR: begin
            cnt_we = 1'b1;
            mark_we = 1'b1;
            wr_addr = clr_ff;
            cnt_wd = '0;
            mark_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(VOXELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = head_addr;
            if (!q_empty) begin
               q_pop = 1'b1;
               cmd_in = q_head;
               used_in = 1'b0;
               value_in = '0;
               case (q_head.kind)
                  CMD_NEAR: begin
                     used_in = 1'b1;
                     cur_in[0] = IDX_W'(q_head.vx);
                     cur_in[1] = IDX_W'(q_head.vy);
                     cur_in[2] = IDX_W'(q_head.vz);
                     state_in = ST_HIT;
                  end
                  CMD_SPHERE: begin
                     used_in = 1'b1;
                     axis_in = '0;
                     empty_in = 1'b0;
                     state_in = ST_DIV_GO;
                  end
                  CMD_EOF: begin
                     if (&epoch_ff) begin
                        // epoch wraps: old marks must go before reuse
                        epoch_in = EPOCH_W'(1);
                        clr_in = '0;
                        state_in = ST_MCLEAR;
                     end else begin
                        epoch_in = epoch_ff + 1'b1;
                        state_in = ST_DONE;
                     end
                  end
                  CMD_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            value_in = cmd_ff.rd_ok ? cnt_rd : '0;
            state_in = ST_DONE;
         end
         ST_DIV_GO, ST_DIV_WAIT: begin
            if (state_ff == ST_DIV_GO && spc_sel != '0) begin
               div_start = 1'b1;
               state_in = ST_DIV_WAIT;
            end else if (state_ff == ST_DIV_GO || div_done) begin
               if (state_ff == ST_DIV_GO) begin
                  // zero spacing spans the whole axis
                  lo_in[axis_ff] = '0;
                  hi_in[axis_ff] = IDX_W'(size_m1);
               end else begin
                  lo_in[axis_ff] = IDX_W'(lo_cl);
                  hi_in[axis_ff] = IDX_W'(hi_cl);
                  empty_in = empty_ff || box_empty;
               end
               if (axis_ff == 2'd2) begin
                  for (int a = 0; a < 3; a++) begin
                     cur_in[a] = lo_in[a];
                  end
                  state_in = empty_in ? ST_DONE : ST_MUL;
               end else begin
                  axis_in = axis_ff + 1'b1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_SQ;
         end
         ST_SQ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (in_sphere) begin
               state_in = ST_HIT;
            end else if (done_box) begin
               state_in = ST_DONE;
            end else begin
               for (int a = 0; a < 3; a++) begin
                  cur_in[a] = nxt[a];
               end
               state_in = ST_MUL;
            end
         end
         ST_HIT: begin
            if (!marked) begin
               cnt_we = 1'b1;
               mark_we = 1'b1;
               if (new_cnt > max_ff) begin
                  max_in = new_cnt;
               end
            end
            if (cmd_ff.kind == CMD_SPHERE && !done_box) begin
               for (int a = 0; a < 3; a++) begin
                  cur_in[a] = nxt[a];
               end
               state_in = ST_MUL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MCLEAR: begin
            mark_we = 1'b1;
            wr_addr = clr_ff;
            mark_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(VOXELS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.count_value = value_ff;
               rsp_in.max_count = max_ff;
               rsp_in.marker_used = used_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         epoch_ff <= EPOCH_W'(1);
         max_ff <= '0;
         rsp_valid_ff <= 1'b0;
         axis_ff <= '0;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         epoch_ff <= epoch_in;
         max_ff <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         axis_ff <= axis_in;
         empty_ff <= empty_in;
      end
      cmd_ff <= cmd_in;
      value_ff <= value_in;
      used_ff <= used_in;
      rsp_ff <= rsp_in;
      r2_ff <= r2_in;
      for (int a = 0; a < 3; a++) begin
         cur_ff[a] <= cur_in[a];
         lo_ff[a] <= lo_in[a];
         hi_ff[a] <= hi_in[a];
         m_ff[a] <= m_in[a];
         t_ff[a] <= t_in[a];
      end
   end

   assign clearing = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import sscd_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   sphere_splat_density_counter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   localparam int STALL_LIMIT = 1500000;

   typedef struct {
      req_type r;
      bit      known;
      rsp_type e;
   } vector_type;

   // shadow of the density map
   bit [CNT_W-1:0] voxel_count [VOXELS];
   int             voxel_file [VOXELS];
   int             file_no;
   bit [CNT_W-1:0] peak_count;
   longint         radius_q;
   longint         spacing_q [3];
   logic signed [FILT_W-1:0] filter_q;

   rsp_type        pending_rsp [$];
   int             error_count;
   int             words_sent;
   int             words_back;
   int             used_markers;
   int             stall_cycles;
   bit             no_idle;
   int             match_pct;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void hit_voxel(longint x, longint y, longint z);
      int idx;
      idx = int'((x * SIZE_Y + y) * SIZE_Z + z);
      if (voxel_file[idx] == file_no) return;
      voxel_file[idx] = file_no;
      if (voxel_count[idx] != 16'hFFFF) voxel_count[idx]++;
      if (voxel_count[idx] > peak_count) peak_count = voxel_count[idx];
   endfunction

   function automatic longint unsigned dist_term(longint i, longint p, longint s);
      longint d;
      longint unsigned m;
      d = i * (longint'(1) << FRAC_BITS) - p;
      m = longint'(d < 0 ? -d : d) * s;
      return m * m;
   endfunction

   function automatic bit splat_marker(req_type r);
      longint p [3];
      longint sz [3];
      longint lo [3];
      longint hi [3];
      longint h, big_r, x, y, z, fv;
      longint unsigned r2, tx, ty, tz;
      p[0] = longint'(r.pos_x);
      p[1] = longint'(r.pos_y);
      p[2] = longint'(r.pos_z);
      sz[0] = SIZE_X;
      sz[1] = SIZE_Y;
      sz[2] = SIZE_Z;
      fv = longint'(filter_q);
      if (fv >= 0 && fv != longint'(r.marker_id) && fv != longint'(r.marker_id) + ID_OFFSET)
         return 1'b0;
      for (int c = 0; c < 3; c++) begin
         if (2 * p[c] < -(longint'(1) << FRAC_BITS) ||
             2 * p[c] >= (2 * sz[c] - 1) * (longint'(1) << FRAC_BITS))
            return 1'b0;
      end
      if (radius_q == 0) begin
         h = longint'(1) << (FRAC_BITS - 1);
         hit_voxel((p[0] + h) >>> FRAC_BITS, (p[1] + h) >>> FRAC_BITS,
                   (p[2] + h) >>> FRAC_BITS);
         return 1'b1;
      end
      big_r = radius_q << FRAC_BITS;
      r2 = big_r * big_r;
      for (int c = 0; c < 3; c++) begin
         if (spacing_q[c] == 0) begin
            lo[c] = 0;
            hi[c] = sz[c] - 1;
         end else begin
            h = big_r / spacing_q[c];
            lo[c] = -((h - p[c]) >>> FRAC_BITS);
            hi[c] = (p[c] + h) >>> FRAC_BITS;
            if (lo[c] < 0) lo[c] = 0;
            if (hi[c] > sz[c] - 1) hi[c] = sz[c] - 1;
         end
      end
      for (x = lo[0]; x <= hi[0]; x++) begin
         tx = dist_term(x, p[0], spacing_q[0]);
         if (tx > r2) continue;
         for (y = lo[1]; y <= hi[1]; y++) begin
            ty = dist_term(y, p[1], spacing_q[1]);
            if (ty > r2 - tx) continue;
            for (z = lo[2]; z <= hi[2]; z++) begin
               tz = dist_term(z, p[2], spacing_q[2]);
               if (tz <= r2 - tx - ty) hit_voxel(x, y, z);
            end
         end
      end
      return 1'b1;
   endfunction

   function automatic rsp_type predict_density(req_type r);
      rsp_type o;
      o = '0;
      case (r.op)
         OP_SPLAT: begin
            o.marker_used = splat_marker(r);
            if (o.marker_used) used_markers++;
         end
         OP_EOF: file_no++;
         OP_READ: o.count_value = voxel_count[vox_addr(r.read_x, r.read_y, r.read_z)];
         default: ;
      endcase
      o.max_count = peak_count;
      return o;
   endfunction

   function automatic req_type mk_word(logic [1:0] op, int x, int y, int z, int id,
                                       int rx, int ry, int rz);
      req_type r;
      r.op = op;
      r.pos_x = x[15:0];
      r.pos_y = y[15:0];
      r.pos_z = z[15:0];
      r.marker_id = id[15:0];
      r.read_x = rx[5:0];
      r.read_y = ry[5:0];
      r.read_z = rz[5:0];
      return r;
   endfunction

   function automatic int rand_pos();
      int k;
      k = $urandom_range(0, 99);
      if (k < 80) return $urandom_range(20 * 256 - 200, 26 * 256 + 200);
      if (k < 90) return $urandom_range(0, 64 * 256) - 300;
      return int'($signed(16'($urandom)));
   endfunction

   function automatic int rand_id();
      int id;
      if (filter_q < 0) return $urandom_range(0, 65535);
      if ($urandom_range(0, 99) < match_pct) begin
         if ($urandom_range(0, 1) == 0 || filter_q < ID_OFFSET) return int'(filter_q);
         return int'(filter_q) - ID_OFFSET;
      end
      do id = $urandom_range(0, 65535);
      while (id == int'(filter_q) || id + ID_OFFSET == int'(filter_q));
      return id;
   endfunction

   function automatic req_type rand_word();
      int k, rx, ry, rz;
      logic [1:0] op;
      k = $urandom_range(0, 99);
      op = (k < 60) ? OP_SPLAT : (k < 64) ? OP_EOF : (k < 94) ? OP_READ : OP_NOP;
      if ($urandom_range(0, 9) < 7) begin
         rx = $urandom_range(18, 28);
         ry = $urandom_range(18, 28);
         rz = $urandom_range(18, 28);
      end else begin
         rx = $urandom_range(0, 63);
         ry = $urandom_range(0, 63);
         rz = $urandom_range(0, 63);
      end
      return mk_word(op, rand_pos(), rand_pos(), rand_pos(), rand_id(), rx, ry, rz);
   endfunction

   // call at a falling edge; returns at a falling edge
   task automatic send_word(req_type r, bit known, rsp_type e);
      int gap;
      rsp_type p;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      p = predict_density(r);
      pending_rsp.push_back(known ? e : p);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= v;
      case (idx)
         CSR_RADIUS: radius_q = longint'(v[15:0]);
         CSR_SPACING_X: spacing_q[0] = longint'(v[15:0]);
         CSR_SPACING_Y: spacing_q[1] = longint'(v[15:0]);
         CSR_SPACING_Z: spacing_q[2] = longint'(v[15:0]);
         CSR_FILTER: filter_q = v;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(int rad, int sx, int sy, int sz, int filt, int mp);
      csr_write(CSR_RADIUS, CSR_DATA_W'(rad));
      csr_write(CSR_SPACING_X, CSR_DATA_W'(sx));
      csr_write(CSR_SPACING_Y, CSR_DATA_W'(sy));
      csr_write(CSR_SPACING_Z, CSR_DATA_W'(sz));
      csr_write(CSR_FILTER, CSR_DATA_W'(filt));
      csr_wr_en <= 1'b0;
      match_pct = mp;
      @(negedge clock);
   endtask

   task automatic run_random(int n, bit pause_mid);
      rsp_type none;
      none = '0;
      for (int i = 0; i < n; i++) begin
         if (pause_mid && i == n / 2) begin
            req_valid <= 1'b0;
            while (pending_rsp.size() != 0) @(negedge clock);
         end
         send_word(rand_word(), 1'b0, none);
      end
      drain();
   endtask

   // directed words, expected values given where they are obvious
   vector_type vec [$];

   task automatic add_vec(req_type r, bit known, int cv, int mx, int used);
      vector_type v;
      v.r = r;
      v.known = known;
      v.e.count_value = cv[15:0];
      v.e.max_count = mx[15:0];
      v.e.marker_used = used[0];
      vec.push_back(v);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      file_no = 1;
      peak_count = '0;
      radius_q = 0;
      spacing_q[0] = 256;
      spacing_q[1] = 256;
      spacing_q[2] = 256;
      filter_q = -1;
      error_count = 0;
      words_sent = 0;
      words_back = 0;
      used_markers = 0;
      no_idle = 1'b0;
      match_pct = 50;

      add_vec(mk_word(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0);
      add_vec(mk_word(OP_SPLAT, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1, 1);
      add_vec(mk_word(OP_SPLAT, 0, 0, 0, 9, 0, 0, 0), 1, 0, 1, 1);
      add_vec(mk_word(OP_EOF, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1, 0);
      add_vec(mk_word(OP_SPLAT, 0, 0, 0, 0, 0, 0, 0), 1, 0, 2, 1);
      add_vec(mk_word(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1, 2, 2, 0);
      add_vec(mk_word(OP_SPLAT, -128, -128, -128, 0, 0, 0, 0), 1, 0, 2, 1);
      add_vec(mk_word(OP_SPLAT, -129, 0, 0, 0, 0, 0, 0), 1, 0, 2, 0);
      add_vec(mk_word(OP_SPLAT, 16255, 16255, 16255, 65535, 0, 0, 0), 1, 0, 2, 1);
      add_vec(mk_word(OP_SPLAT, 16256, 0, 0, 0, 0, 0, 0), 1, 0, 2, 0);
      add_vec(mk_word(OP_SPLAT, 0, 0, 16256, 0, 0, 0, 0), 1, 0, 2, 0);
      add_vec(mk_word(OP_SPLAT, 32767, 32767, 32767, 0, 63, 63, 63), 1, 0, 2, 0);
      add_vec(mk_word(OP_SPLAT, -32768, -32768, -32768, 0, 0, 0, 0), 1, 0, 2, 0);
      add_vec(mk_word(OP_NOP, 32767, -1, 5, 65535, 63, 63, 63), 1, 0, 2, 0);
      add_vec(mk_word(OP_READ, 0, 0, 0, 0, 63, 63, 63), 1, 1, 2, 0);
      add_vec(mk_word(OP_SPLAT, 100, 383, 16000, 17, 0, 0, 0), 0, 0, 0, 0);
      add_vec(mk_word(OP_READ, 0, 0, 0, 0, 0, 1, 62), 0, 0, 0, 0);
      add_vec(mk_word(OP_READ, 0, 0, 0, 0, 63, 0, 63), 1, 0, 2, 0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (vec[i]) send_word(vec[i].r, vec[i].known, vec[i].e);
      drain();

      set_config(0, 256, 256, 256, 1500, 70);
      run_random(150, 0);
      set_config(0, 256, 256, 256, 65535, 70);
      run_random(100, 0);
      set_config(256, 256, 256, 256, 17'h10000, 0);
      run_random(200, 0);
      set_config(512, 256, 128, 384, -1, 0);
      run_random(150, 1);
      set_config(256, 65535, 65535, 0, -1, 0);
      run_random(80, 0);
      no_idle = 1'b1;
      set_config(1, 1, 1, 1, -1, 0);
      run_random(100, 0);
      no_idle = 1'b0;
      set_config(255, 65535, 65535, 65535, 0, 60);
      run_random(100, 0);
      // largest radius only with markers that the filter rejects
      set_config(65535, 256, 256, 256, 3, 0);
      run_random(100, 0);
      set_config(0, 256, 256, 256, -1, 0);
      run_random(190, 0);

      $display("covered %0d words, %0d markers splatted, %0d files, peak count %0d",
               words_sent, used_markers, file_no, peak_count);
      $display("configs: nearest voxel, id filters, spheres incl. zero and extreme spacing");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            words_back++;
            if (pending_rsp.size() == 0) begin
               $error("response word with nothing expected");
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.count_value !== want.count_value) begin
                  $error("count_value: expected %0d, got %0d", want.count_value,
                         rsp_data.count_value);
                  error_count++;
               end
               if (rsp_data.max_count !== want.max_count) begin
                  $error("max_count: expected %0d, got %0d", want.max_count,
                         rsp_data.max_count);
                  error_count++;
               end
               if (rsp_data.marker_used !== want.marker_used) begin
                  $error("marker_used: expected %0d, got %0d", want.marker_used,
                         rsp_data.marker_used);
                  error_count++;
               end
            end
         end
      end
   end

endmodule
